/* src/lcc_pkg.sv */
// ----------------------------------------------------------------------------
// lcc_pkg: shared types and constants for the load cell calibrate/convert core
// Field widths, command and register codes, and the job word that travels
// from the front end to the conversion back end.
// ----------------------------------------------------------------------------
`default_nettype none

package lcc_pkg;

  localparam int ADC_W      = 24;
  localparam int KPA_W      = 16;
  localparam int SUM_W      = ADC_W + 4;       // holds up to 16 full-scale samples
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int CNT_CFG_W  = 2;
  localparam int DIFF_W     = ADC_W + 1;       // signed reading difference
  localparam int KD_W       = KPA_W + 1;       // signed pressure difference
  localparam int QUO_W      = ADC_W + KPA_W;   // product magnitude and quotient

  localparam int DEF_SAMPLE_COUNT = 10;
  localparam int DEF_ADC_BITS     = 24;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [KPA_W-1:0] KPA_MAX = {KPA_W{1'b1}};

  localparam logic [OP_W-1:0] OP_CAL_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_MEAS_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP       = 2'd2;
  localparam logic [OP_W-1:0] OP_SAMPLE     = 2'd3;

  localparam logic KIND_MEAS = 1'b0;
  localparam logic KIND_CAL  = 1'b1;

  localparam logic [CNT_CFG_W-1:0] POINTS_FULL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT0_ADC  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT0_KPA  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINT1_ADC  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT1_KPA  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POINT2_ADC  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POINT2_KPA  = 3'd6;

  typedef struct packed {
    logic [CNT_CFG_W-1:0] point_count;
    logic [ADC_W-1:0]     p0_adc;
    logic [KPA_W-1:0]     p0_kpa;
    logic [ADC_W-1:0]     p1_adc;
    logic [KPA_W-1:0]     p1_kpa;
    logic [ADC_W-1:0]     p2_adc;
    logic [KPA_W-1:0]     p2_kpa;
  } cfg_t;

  typedef struct packed {
    logic             kind;
    logic [KPA_W-1:0] kpa;
    logic [ADC_W-1:0] sample;
    logic [SUM_W-1:0] sum;
    logic [ADC_W-1:0] max_v;
    logic [ADC_W-1:0] min_v;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

/* src/load_cell_calibrate_and_convert_core.sv */
// Flow: commands and non-final samples only update the front end; a final
//   calibration or measurement sample is queued, then popped, given two or three
//   setup steps and 40 divider steps, and written to the result register once free.
// Engine: the 40-step serial divider is shared by averaging and interpolation;
//   one job is worked at a time and two jobs may queue.
// Reset: synchronous active-low; clears mode, accumulators, queue, config.
// ----------------------------------------------------------------------------
// load_cell_calibrate_and_convert_core: load cell front end top level
// Configuration registers, command front end, job queue and conversion engine.
// ----------------------------------------------------------------------------
`default_nettype none

module load_cell_calibrate_and_convert_core #(
  parameter int SAMPLE_COUNT = lcc_pkg::DEF_SAMPLE_COUNT,
  parameter int ADC_BITS     = lcc_pkg::DEF_ADC_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [lcc_pkg::OP_W-1:0]       in_opcode,
  input  wire logic [lcc_pkg::ADC_W-1:0]      in_adc_value,
  input  wire logic [lcc_pkg::KPA_W-1:0]      in_ref_kpa,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_result_kind,
  output logic [lcc_pkg::KPA_W-1:0]           out_pressure_kpa,
  output logic [lcc_pkg::ADC_W-1:0]           out_adc_average,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lcc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lcc_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  q_status_t q_stat;
  job_t      push_job;
  job_t      pop_job;
  logic      push;
  logic      pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POINT_COUNT: cfg_nxt.point_count = cfg_data[CNT_CFG_W-1:0];
        REG_POINT0_ADC:  cfg_nxt.p0_adc      = cfg_data[ADC_W-1:0];
        REG_POINT0_KPA:  cfg_nxt.p0_kpa      = cfg_data[KPA_W-1:0];
        REG_POINT1_ADC:  cfg_nxt.p1_adc      = cfg_data[ADC_W-1:0];
        REG_POINT1_KPA:  cfg_nxt.p1_kpa      = cfg_data[KPA_W-1:0];
        REG_POINT2_ADC:  cfg_nxt.p2_adc      = cfg_data[ADC_W-1:0];
        REG_POINT2_KPA:  cfg_nxt.p2_kpa      = cfg_data[KPA_W-1:0];
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lcc_front #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .ADC_BITS     (ADC_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_adc_value (in_adc_value),
    .in_ref_kpa   (in_ref_kpa),
    .point_count  (cfg_r.point_count),
    .q_stat       (q_stat),
    .push         (push),
    .push_job     (push_job)
  );

  lcc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  lcc_back #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_stat           (q_stat),
    .pop_job          (pop_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_pressure_kpa (out_pressure_kpa),
    .out_adc_average  (out_adc_average)
  );

endmodule

`default_nettype wire

/* src/lcc_front.sv */
// ----------------------------------------------------------------------------
// lcc_front: command decode and calibration accumulation
// Tracks the mode, sums calibration samples with running max/min, and hands
// a finished calibration or a measurement sample to the queue as one job.
// ----------------------------------------------------------------------------
`default_nettype none

module lcc_front #(
  parameter int SAMPLE_COUNT = lcc_pkg::DEF_SAMPLE_COUNT,
  parameter int ADC_BITS     = lcc_pkg::DEF_ADC_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [lcc_pkg::OP_W-1:0]    in_opcode,
  input  wire logic [lcc_pkg::ADC_W-1:0]   in_adc_value,
  input  wire logic [lcc_pkg::KPA_W-1:0]   in_ref_kpa,
  input  wire logic [lcc_pkg::CNT_CFG_W-1:0] point_count,
  input  wire lcc_pkg::q_status_t          q_stat,
  output logic                             push,
  output lcc_pkg::job_t                    push_job
);
  import lcc_pkg::*;

  localparam int CNT_W  = $clog2(SAMPLE_COUNT + 1);
  localparam int SUMW_L = ADC_W + $clog2(SAMPLE_COUNT);
  localparam logic [ADC_W-1:0] ADC_MASK = (ADC_BITS >= ADC_W) ? {ADC_W{1'b1}} :
                                          ADC_W'((64'd1 << ADC_BITS) - 64'd1);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_CAL  = 2'd1;
  localparam logic [1:0] MODE_MEAS = 2'd2;

  logic [1:0]        mode_r, mode_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic [SUMW_L-1:0] sum_r, sum_nxt;
  logic [ADC_W-1:0]  max_r, max_nxt;
  logic [ADC_W-1:0]  min_r, min_nxt;
  logic [KPA_W-1:0]  held_r, held_nxt;

  logic              accept;
  logic [ADC_W-1:0]  sample_a;
  logic [SUMW_L-1:0] sum_add;
  logic [ADC_W-1:0]  max_new;
  logic [ADC_W-1:0]  min_new;

  assign in_stall = q_stat.full;
  assign accept   = in_valid & ~in_stall;
  assign sample_a = in_adc_value & ADC_MASK;
  assign sum_add  = sum_r + SUMW_L'(sample_a);
  assign max_new  = (sample_a > max_r) ? sample_a : max_r;
  assign min_new  = (sample_a < min_r) ? sample_a : min_r;

  always_comb begin
    mode_nxt = mode_r;
    left_nxt = left_r;
    sum_nxt  = sum_r;
    max_nxt  = max_r;
    min_nxt  = min_r;
    held_nxt = held_r;
    push     = 1'b0;
    push_job.kind   = KIND_CAL;
    push_job.kpa    = held_r;
    push_job.sample = sample_a;
    push_job.sum    = SUM_W'(sum_add);
    push_job.max_v  = max_new;
    push_job.min_v  = min_new;
    if (accept) begin
      case (in_opcode)
        OP_CAL_START: begin
          held_nxt = in_ref_kpa;
          left_nxt = CNT_W'(SAMPLE_COUNT);
          sum_nxt  = '0;
          max_nxt  = '0;
          min_nxt  = {ADC_W{1'b1}};
          mode_nxt = MODE_CAL;
        end
        OP_MEAS_START: mode_nxt = MODE_MEAS;
        OP_STOP:       mode_nxt = MODE_IDLE;
        OP_SAMPLE: begin
          if (mode_r == MODE_CAL) begin
            sum_nxt = sum_add;
            max_nxt = max_new;
            min_nxt = min_new;
            if (left_r > CNT_W'(1)) begin
              left_nxt = left_r - CNT_W'(1);
            end else begin
              // last sample: ship the totals, trimming happens downstream
              left_nxt = '0;
              push     = 1'b1;
              mode_nxt = MODE_IDLE;
            end
          end else if (mode_r == MODE_MEAS && point_count == POINTS_FULL) begin
            push          = 1'b1;
            push_job.kind = KIND_MEAS;
            mode_nxt      = MODE_IDLE;
          end
        end
        default: mode_nxt = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      left_r <= '0;
      sum_r  <= '0;
      max_r  <= '0;
      min_r  <= {ADC_W{1'b1}};
      held_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      left_r <= left_nxt;
      sum_r  <= sum_nxt;
      max_r  <= max_nxt;
      min_r  <= min_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/lcc_queue.sv */
// ----------------------------------------------------------------------------
// lcc_queue: short job queue between front end and back end
// Circular buffer with count; lets either side stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module lcc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire lcc_pkg::job_t push_job,
  input  wire logic          pop,
  output lcc_pkg::job_t      pop_job,
  output lcc_pkg::q_status_t q_stat
);
  import lcc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push & ~q_stat.full;
  assign do_pop       = pop & ~q_stat.empty;
  assign pop_job      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/lcc_back.sv */
// ----------------------------------------------------------------------------
// lcc_back: trimmed mean and piecewise linear conversion engine
// Sequencer around one multiplier and a shared radix-2 restoring divider;
// drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcc_back #(
  parameter int SAMPLE_COUNT = lcc_pkg::DEF_SAMPLE_COUNT
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire lcc_pkg::cfg_t             cfg,
  input  wire lcc_pkg::q_status_t        q_stat,
  input  wire lcc_pkg::job_t             pop_job,
  output logic                           pop,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_result_kind,
  output logic [lcc_pkg::KPA_W-1:0]      out_pressure_kpa,
  output logic [lcc_pkg::ADC_W-1:0]      out_adc_average
);
  import lcc_pkg::*;

  localparam int IT_W = $clog2(QUO_W + 1);
  localparam logic [ADC_W-1:0] CAL_DIVISOR = ADC_W'(SAMPLE_COUNT - 2);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_ABS  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  job_t              job_r, job_nxt;
  logic [KD_W-1:0]   kd_r, kd_nxt;
  logic [DIFF_W-1:0] ad_r, ad_nxt;
  logic [DIFF_W-1:0] den_r, den_nxt;
  logic [KPA_W-1:0]  kb_r, kb_nxt;
  logic              zero_r, zero_nxt;
  logic [DIFF_W-1:0] cut_r, cut_nxt;
  logic [KPA_W-1:0]  kd_mag_r, kd_mag_nxt;
  logic [ADC_W-1:0]  ad_mag_r, ad_mag_nxt;
  logic              neg_r, neg_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [ADC_W-1:0]  rem_r, rem_nxt;
  logic [ADC_W-1:0]  dvsr_r, dvsr_nxt;
  logic [IT_W-1:0]   iter_r, iter_nxt;
  logic              ov_r, ov_nxt;
  logic              kind_r, kind_nxt;
  logic [KPA_W-1:0]  press_r, press_nxt;
  logic [ADC_W-1:0]  avg_r, avg_nxt;

  logic              sel_hi;
  logic [ADC_W-1:0]  ab, ae;
  logic [KPA_W-1:0]  kb, ke;
  logic [SUM_W-1:0]  cut_w;
  logic [ADC_W:0]    rem_sh;
  logic              rem_ge;
  logic [QUO_W:0]    pos_sum;
  logic [KPA_W-1:0]  conv;

  assign out_valid        = ov_r;
  assign out_result_kind  = kind_r;
  assign out_pressure_kpa = press_r;
  assign out_adc_average  = avg_r;
  assign pop              = (state_r == ST_IDLE) & ~q_stat.empty;

  // segment select
  assign sel_hi = job_r.sample >= cfg.p1_adc;
  assign ab     = sel_hi ? cfg.p1_adc : cfg.p0_adc;
  assign ae     = sel_hi ? cfg.p2_adc : cfg.p1_adc;
  assign kb     = sel_hi ? cfg.p1_kpa : cfg.p0_kpa;
  assign ke     = sel_hi ? cfg.p2_kpa : cfg.p1_kpa;

  assign cut_w  = SUM_W'(cut_r);
  assign rem_sh = {rem_r, quo_r[QUO_W-1]};
  assign rem_ge = rem_sh >= {1'b0, dvsr_r};

  // final add and clamp of the conversion
  assign pos_sum = {1'b0, quo_r} + (QUO_W + 1)'(kb_r);
  always_comb begin
    if (zero_r) begin
      conv = '0;
    end else if (neg_r) begin
      conv = (quo_r > QUO_W'(kb_r)) ? '0 : kb_r - KPA_W'(quo_r);
    end else begin
      conv = (pos_sum > (QUO_W + 1)'(KPA_MAX)) ? KPA_MAX : KPA_W'(pos_sum);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    kd_nxt     = kd_r;
    ad_nxt     = ad_r;
    den_nxt    = den_r;
    kb_nxt     = kb_r;
    zero_nxt   = zero_r;
    cut_nxt    = cut_r;
    kd_mag_nxt = kd_mag_r;
    ad_mag_nxt = ad_mag_r;
    neg_nxt    = neg_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    dvsr_nxt   = dvsr_r;
    iter_nxt   = iter_r;
    ov_nxt     = ov_r & out_stall;
    kind_nxt   = kind_r;
    press_nxt  = press_r;
    avg_nxt    = avg_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          job_nxt   = pop_job;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        den_nxt  = {1'b0, ae} - {1'b0, ab};
        ad_nxt   = {1'b0, job_r.sample} - {1'b0, ab};
        kd_nxt   = {1'b0, ke} - {1'b0, kb};
        kb_nxt   = kb;
        zero_nxt = (ae == ab);
        cut_nxt  = {1'b0, job_r.max_v} + {1'b0, job_r.min_v};
        state_nxt = ST_ABS;
      end
      ST_ABS: begin
        kd_mag_nxt = KPA_W'(kd_r[KD_W-1] ? -kd_r : kd_r);
        ad_mag_nxt = ADC_W'(ad_r[DIFF_W-1] ? -ad_r : ad_r);
        dvsr_nxt   = ADC_W'(den_r[DIFF_W-1] ? -den_r : den_r);
        neg_nxt    = kd_r[KD_W-1] ^ ad_r[DIFF_W-1] ^ den_r[DIFF_W-1];
        rem_nxt    = '0;
        iter_nxt   = IT_W'(QUO_W);
        if (job_r.kind == KIND_CAL) begin
          // drop largest and smallest, clamp at zero
          quo_nxt   = (job_r.sum >= cut_w) ? QUO_W'(job_r.sum - cut_w) : '0;
          dvsr_nxt  = CAL_DIVISOR;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        quo_nxt   = QUO_W'(kd_mag_r) * QUO_W'(ad_mag_r);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt  = rem_ge ? ADC_W'(rem_sh - {1'b0, dvsr_r}) : ADC_W'(rem_sh);
        quo_nxt  = {quo_r[QUO_W-2:0], rem_ge};
        iter_nxt = iter_r - IT_W'(1);
        if (iter_r == IT_W'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the result register frees up
        if (!ov_r || !out_stall) begin
          ov_nxt   = 1'b1;
          kind_nxt = job_r.kind;
          if (job_r.kind == KIND_CAL) begin
            press_nxt = job_r.kpa;
            avg_nxt   = quo_r[ADC_W-1:0];
          end else begin
            press_nxt = conv;
            avg_nxt   = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    kd_r     <= kd_nxt;
    ad_r     <= ad_nxt;
    den_r    <= den_nxt;
    kb_r     <= kb_nxt;
    zero_r   <= zero_nxt;
    cut_r    <= cut_nxt;
    kd_mag_r <= kd_mag_nxt;
    ad_mag_r <= ad_mag_nxt;
    neg_r    <= neg_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    dvsr_r   <= dvsr_nxt;
    iter_r   <= iter_nxt;
    kind_r   <= kind_nxt;
    press_r  <= press_nxt;
    avg_r    <= avg_nxt;
  end

endmodule

`default_nettype wire

/* src/lcc_checker.sv */
// ----------------------------------------------------------------------------
// lcc_checker: port-level assertions for the load cell core
// Watches reset behavior, result register hold and measurement word format.
// ----------------------------------------------------------------------------
`default_nettype none

module lcc_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic [lcc_pkg::OP_W-1:0]       in_opcode,
  input wire logic [lcc_pkg::ADC_W-1:0]      in_adc_value,
  input wire logic [lcc_pkg::KPA_W-1:0]      in_ref_kpa,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic                           out_result_kind,
  input wire logic [lcc_pkg::KPA_W-1:0]      out_pressure_kpa,
  input wire logic [lcc_pkg::ADC_W-1:0]      out_adc_average,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic [lcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [lcc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lcc_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind) &&
      $stable(out_pressure_kpa) && $stable(out_adc_average))
    else $error("result word changed while stalled");

  // measurement words carry no average
  a_meas_avg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_MEAS |-> out_adc_average == '0)
    else $error("measurement word with nonzero average");

  // reset empties the result register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // reset empties the job queue, so input is open
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind load_cell_calibrate_and_convert_core lcc_checker u_lcc_checker (.*);

`default_nettype wire

/* test/lcc_result_checker.sv */
// ----------------------------------------------------------------------------
// lcc_result_checker: result predictor and comparator for the load cell core
// Watches the command, register and result channels. Tracks the calibration
// and measurement state of the core, works out each calibration average and
// converted pressure, and compares every accepted result word, field by field,
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module lcc_result_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire logic [lcc_pkg::OP_W-1:0]       in_opcode,
  input  wire logic [lcc_pkg::ADC_W-1:0]      in_adc_value,
  input  wire logic [lcc_pkg::KPA_W-1:0]      in_ref_kpa,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire logic                           out_result_kind,
  input  wire logic [lcc_pkg::KPA_W-1:0]      out_pressure_kpa,
  input  wire logic [lcc_pkg::ADC_W-1:0]      out_adc_average,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [lcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lcc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                  mismatches,
  output int                                  outstanding,
  output int                                  cal_results,
  output int                                  meas_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcc_pkg::*;

  typedef enum logic [1:0] {MODE_IDLE, MODE_CAL, MODE_MEAS} mode_e;

  typedef struct packed {
    logic             kind;
    logic [KPA_W-1:0] kpa;
    logic [ADC_W-1:0] average;
  } reading_t;

  localparam longint TRIM_DIV = DEF_SAMPLE_COUNT - 2;

  reading_t         expected_readings[$];
  cfg_t             points;
  mode_e            mode;
  logic [3:0]       samples_left;
  logic [SUM_W-1:0] running_sum;
  logic [ADC_W-1:0] largest;
  logic [ADC_W-1:0] smallest;
  logic [KPA_W-1:0] held_ref;

  // Linear segment through (ab, kb) and (ae, ke), quotient toward zero, clamped.
  function automatic logic [KPA_W-1:0] segment_kpa(longint a, longint ab, longint kb,
                                                   longint ae, longint ke);
    longint span;
    longint level;
    span = ae - ab;
    if (span == 0) return '0;
    level = kb + ((ke - kb) * (a - ab)) / span;
    if (level < 0) return '0;
    if (level > longint'(KPA_MAX)) return KPA_MAX;
    return level[KPA_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t lcc checker: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    reading_t         got;
    reading_t         want;
    logic [ADC_W-1:0] a;
    logic [KPA_W-1:0] kpa;
    longint           cut;
    longint           trimmed;
    if (!rst_n) begin
      expected_readings.delete();
      points       = '0;
      mode         = MODE_IDLE;
      samples_left = '0;
      running_sum  = '0;
      largest      = '0;
      smallest     = '1;
      held_ref     = '0;
      mismatches   = 0;
      cal_results  = 0;
      meas_results = 0;
    end else begin
      // A result can never belong to a word accepted on the same edge.
      if (out_valid && !out_stall) begin
        got = '{out_result_kind, out_pressure_kpa, out_adc_average};
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("result with none pending: kind %0d kpa %0d avg %h",
                                    got.kind, got.kpa, got.average));
        end else begin
          want = expected_readings.pop_front();
          if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
          if (got.kpa !== want.kpa)
            report_mismatch($sformatf("pressure %0d, want %0d", got.kpa, want.kpa));
          if (got.average !== want.average)
            report_mismatch($sformatf("average %h, want %h", got.average, want.average));
          if (want.kind == KIND_CAL) cal_results++;
          else meas_results++;
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_POINT_COUNT: points.point_count = cfg_data[CNT_CFG_W-1:0];
          REG_POINT0_ADC:  points.p0_adc      = cfg_data[ADC_W-1:0];
          REG_POINT0_KPA:  points.p0_kpa      = cfg_data[KPA_W-1:0];
          REG_POINT1_ADC:  points.p1_adc      = cfg_data[ADC_W-1:0];
          REG_POINT1_KPA:  points.p1_kpa      = cfg_data[KPA_W-1:0];
          REG_POINT2_ADC:  points.p2_adc      = cfg_data[ADC_W-1:0];
          REG_POINT2_KPA:  points.p2_kpa      = cfg_data[KPA_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        a = in_adc_value;
        case (in_opcode)
          OP_CAL_START: begin
            held_ref     = in_ref_kpa;
            samples_left = 4'(DEF_SAMPLE_COUNT);
            running_sum  = '0;
            largest      = '0;
            smallest     = '1;
            mode         = MODE_CAL;
          end
          OP_MEAS_START: mode = MODE_MEAS;
          OP_STOP:       mode = MODE_IDLE;
          default: begin
            if (mode == MODE_CAL) begin
              running_sum = running_sum + SUM_W'(a);
              if (a > largest) largest = a;
              if (a < smallest) smallest = a;
              if (samples_left > 4'd1) begin
                samples_left = samples_left - 4'd1;
              end else begin
                samples_left = '0;
                cut     = longint'(largest) + longint'(smallest);
                trimmed = longint'(running_sum);
                trimmed = (trimmed >= cut) ? trimmed - cut : 0;
                trimmed = trimmed / TRIM_DIV;
                expected_readings.push_back('{KIND_CAL, held_ref, trimmed[ADC_W-1:0]});
                mode = MODE_IDLE;
              end
            end else if (mode == MODE_MEAS && points.point_count == POINTS_FULL) begin
              if (a >= points.p1_adc)
                kpa = segment_kpa(a, points.p1_adc, points.p1_kpa,
                                  points.p2_adc, points.p2_kpa);
              else
                kpa = segment_kpa(a, points.p0_adc, points.p0_kpa,
                                  points.p1_adc, points.p1_kpa);
              expected_readings.push_back('{KIND_MEAS, kpa, '0});
              mode = MODE_IDLE;
            end
          end
        endcase
      end
    end
    outstanding = expected_readings.size();
  end

endmodule

/* test/load_cell_calibrate_and_convert_core_test.sv */
// ----------------------------------------------------------------------------
// load_cell_calibrate_and_convert_core_test: top level test of the load cell core
// Drives command and sample words with random gaps and result stalls, loads
// several sets of calibration points between phases, and leaves prediction and
// comparison to the result checker beside the core.
// ----------------------------------------------------------------------------
module load_cell_calibrate_and_convert_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lcc_pkg::*;

  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 1_000_000;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_opcode        = OP_STOP;
  logic [ADC_W-1:0]      in_adc_value     = '0;
  logic [KPA_W-1:0]      in_ref_kpa       = '0;
  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  logic                  out_result_kind;
  logic [KPA_W-1:0]      out_pressure_kpa;
  logic [ADC_W-1:0]      out_adc_average;
  logic                  cfg_valid        = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;

  int   mismatches;
  int   outstanding;
  int   cal_results;
  int   meas_results;
  int   cycles     = 0;
  int   words_sent = 0;
  int   cfg_writes = 0;
  int   hold_asks  = 0;
  bit   quiet_in   = 1'b0;
  bit   quiet_out  = 1'b0;
  cfg_t points     = '0;

  always #5 clk = ~clk;

  load_cell_calibrate_and_convert_core dut (.*);

  lcc_result_checker result_check (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("load cell run: stuck after %0d cycles, %0d results pending",
               cycles, outstanding);
      $display("load_cell_calibrate_and_convert_core_test: errors");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : result_pacing
    int stall_left = 0;
    int holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = quiet_out ? 0 : pick_gap();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  function automatic cfg_t make_points(logic [CNT_CFG_W-1:0] n,
                                       logic [ADC_W-1:0] a0, logic [KPA_W-1:0] k0,
                                       logic [ADC_W-1:0] a1, logic [KPA_W-1:0] k1,
                                       logic [ADC_W-1:0] a2, logic [KPA_W-1:0] k2);
    cfg_t c;
    c.point_count = n;
    c.p0_adc = a0;
    c.p0_kpa = k0;
    c.p1_adc = a1;
    c.p1_kpa = k1;
    c.p2_adc = a2;
    c.p2_kpa = k2;
    return c;
  endfunction

  function automatic cfg_t random_points(bit descending);
    logic [ADC_W-1:0] a [3];
    logic [ADC_W-1:0] t;
    for (int i = 0; i < 3; i++) a[i] = ADC_W'($urandom());
    if (a[0] > a[1]) begin t = a[0]; a[0] = a[1]; a[1] = t; end
    if (a[1] > a[2]) begin t = a[1]; a[1] = a[2]; a[2] = t; end
    if (a[0] > a[1]) begin t = a[0]; a[0] = a[1]; a[1] = t; end
    if (descending) begin t = a[0]; a[0] = a[2]; a[2] = t; end
    return make_points(POINTS_FULL, a[0], KPA_W'($urandom()), a[1], KPA_W'($urandom()),
                       a[2], KPA_W'($urandom()));
  endfunction

  function automatic logic [ADC_W-1:0] cal_reading(logic [ADC_W-1:0] base);
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return base + ADC_W'($urandom_range(0, 4095));
      default:    return ADC_W'($urandom());
    endcase
  endfunction

  // Aim at the segment edges as well as anywhere in range.
  function automatic logic [ADC_W-1:0] reading_near_points(cfg_t c);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return c.p0_adc;
      3:       return c.p1_adc;
      4:       return c.p2_adc;
      5:       return c.p1_adc - 1'b1;
      6:       return c.p0_adc - 1'b1;
      7:       return c.p2_adc + 1'b1;
      8, 9:    return ADC_W'($urandom_range(c.p0_adc, c.p1_adc));
      default: return ADC_W'($urandom());
    endcase
  endfunction

  // Keep valid high between back-to-back words; drop it only for a gap.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [ADC_W-1:0] adc,
                           input logic [KPA_W-1:0] kpa);
    int gap;
    gap = quiet_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_adc_value <= adc;
    in_ref_kpa   <= kpa;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic send_command(input logic [OP_W-1:0] op);
    send_word(op, ADC_W'($urandom()), KPA_W'($urandom()));
  endtask

  task automatic send_sample(input logic [ADC_W-1:0] adc);
    send_word(OP_SAMPLE, adc, KPA_W'($urandom()));
  endtask

  task automatic measurement_of(input logic [ADC_W-1:0] adc);
    send_command(OP_MEAS_START);
    send_sample(adc);
  endtask

  task automatic calibration_run(input int n);
    logic [ADC_W-1:0] base;
    base = ADC_W'($urandom());
    send_command(OP_CAL_START);
    repeat (n) send_sample(cal_reading(base));
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 4))
      0: send_sample(ADC_W'($urandom()));
      1: send_command(OP_STOP);
      2: begin
        calibration_run($urandom_range(1, DEF_SAMPLE_COUNT - 1));
        send_command(OP_STOP);
      end
      3: begin
        send_command(OP_MEAS_START);
        measurement_of(reading_near_points(points));
      end
      default: begin
        calibration_run($urandom_range(1, DEF_SAMPLE_COUNT - 1));
        measurement_of(reading_near_points(points));
      end
    endcase
  endtask

  task automatic mix_traffic(input int n);
    int first;
    int r;
    first = words_sent;
    while (words_sent - first < n) begin
      r = $urandom_range(0, 99);
      if (r < 40) calibration_run(DEF_SAMPLE_COUNT);
      else if (r < 85) measurement_of(reading_near_points(points));
      else send_noise();
    end
  endtask

  // Hold off until every predicted result is out and the engine has gone quiet.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_points(input cfg_t c);
    logic [CFG_IDX_W-1:0]  idx [8];
    logic [CFG_DATA_W-1:0] val [8];
    idx = '{REG_POINT_COUNT, REG_POINT0_ADC, REG_POINT0_KPA, REG_POINT1_ADC,
            REG_POINT1_KPA, REG_POINT2_ADC, REG_POINT2_KPA, REG_UNUSED};
    // Unused upper data bits carry junk; the core keeps only the field width.
    for (int i = 0; i < 8; i++) val[i] = CFG_DATA_W'($urandom());
    val[0][CNT_CFG_W-1:0] = c.point_count;
    val[1]                = c.p0_adc;
    val[2][KPA_W-1:0]     = c.p0_kpa;
    val[3]                = c.p1_adc;
    val[4][KPA_W-1:0]     = c.p1_kpa;
    val[5]                = c.p2_adc;
    val[6][KPA_W-1:0]     = c.p2_kpa;
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
    points = c;
  endtask

  task automatic run_phase(input cfg_t c, input int n);
    wait_for_results();
    load_points(c);
    mix_traffic(n);
  endtask

  initial begin : stimulus
    cfg_t shared_pts;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Registers still at reset: measure gets no answer, stray sample is dropped.
    measurement_of(24'h123456);
    send_command(OP_STOP);
    send_sample('1);
    wait_for_results();

    load_points(make_points(POINTS_FULL, 24'h100000, 16'd1000, 24'h800000, 16'd40000,
                            24'hF00000, KPA_MAX));
    send_word(OP_CAL_START, ADC_W'($urandom()), KPA_MAX);
    send_sample('0);
    send_sample('1);
    for (int i = 2; i < DEF_SAMPLE_COUNT; i++) send_sample(24'h400000 + ADC_W'(i * 4096));
    send_word(OP_CAL_START, ADC_W'($urandom()), 16'd77);
    send_command(OP_STOP);
    measurement_of('0);
    measurement_of('1);
    measurement_of(24'h800000);

    run_phase(random_points(1'b0), 250);

    quiet_in  = 1'b1;
    quiet_out = 1'b1;
    run_phase(make_points(POINTS_FULL, '0, '0, 24'h7FFFFF, 16'h8000, '1, KPA_MAX), 250);
    quiet_in  = 1'b0;
    quiet_out = 1'b0;

    run_phase(random_points(1'b1), 200);

    shared_pts = random_points(1'b0);
    shared_pts.p1_adc = shared_pts.p0_adc;
    run_phase(shared_pts, 150);

    run_phase(make_points(POINTS_FULL, '0, '0, '0, '0, '0, '0), 100);
    run_phase(make_points(POINTS_FULL, '1, KPA_MAX, '1, KPA_MAX, '1, KPA_MAX), 100);

    shared_pts = random_points(1'b0);
    shared_pts.point_count = CNT_CFG_W'($urandom_range(0, 2));
    run_phase(shared_pts, 100);

    // Long result hold while words keep coming: the queue fills and input backs up.
    wait_for_results();
    load_points(random_points(1'b0));
    quiet_in = 1'b1;
    hold_asks++;
    repeat (15) measurement_of(reading_near_points(points));
    quiet_in = 1'b0;
    mix_traffic(250);

    wait_for_results();
    $display("load cell run: %0d words, %0d register writes, %0d cal and %0d meas results",
             words_sent, cfg_writes, cal_results, meas_results);
    $display("load cell run: ordered/reversed/shared/zero/full/partial points, one long hold");
    if (mismatches == 0) begin
      $display("load_cell_calibrate_and_convert_core_test: clean");
    end else begin
      $display("load_cell_calibrate_and_convert_core_test: errors");
    end
    $finish;
  end

endmodule
